### rtl/core/tetn_pkg.sv
// tetn_pkg: shared types and defaults for the timed event table
// no dependencies
`default_nettype none

package tetn_pkg;

    localparam int DEPTH_DEF        = 64;
    localparam int TIME_BITS_DEF    = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_ADD     = 2'd1,
        OP_CLOSEST = 2'd2,
        OP_BEFORE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

endpackage

`default_nettype wire

### rtl/core/tetn_ram.sv
// tetn_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tetn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/core/timed_event_table_nearest.sv
// timed_event_table_nearest: sorted table of (time, payload) events with
// clear, sorted add, closest and closest-at-or-before lookups
// depends on tetn_pkg and tetn_ram
//
//   channel  direction  handshake                 fields
//   in       input      i_in_valid / o_in_stall    i_op, i_time_pos, i_payload
//   out      output     o_out_valid / i_out_stall  o_status, o_found_time,
//                                                   o_found_payload, o_event_count,
//                                                   o_last_time
//
// one item at a time; clear and add to a full or empty table go from S_IDLE to S_RESP
// add scans down from the last entry, one ram read per entry, moving each later one up
// lookups scan every stored entry from the first, one compare per entry
// reset empties the table at once; the ram itself is not cleared
// a stalled result holds the finished item in S_RESP, the input stays stalled
`default_nettype none

module timed_event_table_nearest #(
    parameter int DEPTH        = tetn_pkg::DEPTH_DEF,
    parameter int TIME_BITS    = tetn_pkg::TIME_BITS_DEF,
    parameter int PAYLOAD_BITS = tetn_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire tetn_pkg::t_op              i_op,
    input  wire logic [TIME_BITS-1:0]       i_time_pos,
    input  wire logic [PAYLOAD_BITS-1:0]    i_payload,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output tetn_pkg::t_status               o_status,
    output logic [TIME_BITS-1:0]            o_found_time,
    output logic [PAYLOAD_BITS-1:0]         o_found_payload,
    output logic [$clog2(DEPTH+1)-1:0]      o_event_count,
    output logic [TIME_BITS-1:0]            o_last_time
);

    import tetn_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = TIME_BITS + PAYLOAD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_LAST,
        S_LK_SCAN,
        S_RESP
    } t_state;

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [TIME_BITS-1:0]    r_t, n_t;
    logic [PAYLOAD_BITS-1:0] r_p, n_p;
    logic [CW-1:0]           r_count, n_count;
    logic [TIME_BITS-1:0]    r_last, n_last;
    logic [AW-1:0]           r_idx, n_idx;
    logic                    r_have, n_have;
    logic [TIME_BITS-1:0]    r_best_t, n_best_t;
    logic [PAYLOAD_BITS-1:0] r_best_p, n_best_p;
    logic [TIME_BITS-1:0]    r_best_d, n_best_d;
    t_status                 r_res, n_res;

    logic                    r_out_valid, n_out_valid;
    t_status                 r_status, n_status;
    logic [TIME_BITS-1:0]    r_found_time, n_found_time;
    logic [PAYLOAD_BITS-1:0] r_found_payload, n_found_payload;
    logic [CW-1:0]           r_event_count, n_event_count;
    logic [TIME_BITS-1:0]    r_last_time, n_last_time;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [EW-1:0]           wr_data;
    logic [AW-1:0]           rd_addr;
    logic [EW-1:0]           rd_data;

    logic [TIME_BITS-1:0]    rd_t;
    logic [PAYLOAD_BITS-1:0] rd_p;
    logic [TIME_BITS-1:0]    abs_diff;
    logic                    take;
    logic                    in_acc;
    logic                    idx_last;

    tetn_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_t     = rd_data[EW-1:PAYLOAD_BITS];
    assign rd_p     = rd_data[PAYLOAD_BITS-1:0];
    assign abs_diff = (rd_t > r_t) ? (rd_t - r_t) : (r_t - rd_t);
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign idx_last = (CW'(r_idx) + CW'(1)) == r_count;

    always_comb begin
        if (r_op == OP_CLOSEST) begin
            take = !r_have || (abs_diff < r_best_d);
        end else begin
            take = (rd_t <= r_t) && (!r_have || (rd_t > r_best_t));
        end
    end

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        n_t             = r_t;
        n_p             = r_p;
        n_count         = r_count;
        n_last          = r_last;
        n_idx           = r_idx;
        n_have          = r_have;
        n_best_t        = r_best_t;
        n_best_p        = r_best_p;
        n_best_d        = r_best_d;
        n_res           = r_res;
        n_out_valid     = r_out_valid && i_out_stall;
        n_status        = r_status;
        n_found_time    = r_found_time;
        n_found_payload = r_found_payload;
        n_event_count   = r_event_count;
        n_last_time     = r_last_time;
        wr_en           = 1'b0;
        wr_addr         = r_idx + AW'(1);
        wr_data         = {r_t, r_p};
        rd_addr         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op   = i_op;
                    n_t    = i_time_pos;
                    n_p    = i_payload;
                    n_have = 1'b0;
                    n_res  = ST_OK;
                    n_idx  = '0;
                    unique case (i_op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_RESP;
                        end
                        OP_ADD: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_res   = ST_FULL;
                                n_state = S_RESP;
                            end else if (r_count == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = {i_time_pos, i_payload};
                                n_last  = i_time_pos;
                                n_count = CW'(1);
                                n_state = S_RESP;
                            end else begin
                                rd_addr = AW'(r_count - CW'(1));
                                n_idx   = AW'(r_count - CW'(1));
                                n_state = S_ADD_SCAN;
                            end
                        end
                        OP_CLOSEST, OP_BEFORE: begin
                            if (r_count == '0) begin
                                n_res   = ST_NOT_FOUND;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_LK_SCAN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_SCAN: begin
                wr_en = 1'b1;
                if (rd_t >= r_t) begin
                    wr_data = rd_data;
                    if (r_idx == '0) begin
                        n_state = S_ADD_LAST;
                    end else begin
                        rd_addr = r_idx - AW'(1);
                        n_idx   = r_idx - AW'(1);
                    end
                end else begin
                    if (idx_last) begin
                        n_last = r_t;
                    end
                    n_count = r_count + CW'(1);
                    n_state = S_RESP;
                end
            end
            S_ADD_LAST: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                n_count = r_count + CW'(1);
                n_state = S_RESP;
            end
            S_LK_SCAN: begin
                if (take) begin
                    n_have   = 1'b1;
                    n_best_t = rd_t;
                    n_best_p = rd_p;
                    n_best_d = abs_diff;
                end
                if (idx_last) begin
                    n_res   = (r_have || take) ? ST_OK : ST_NOT_FOUND;
                    n_state = S_RESP;
                end else begin
                    rd_addr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid     = 1'b1;
                    n_status        = r_res;
                    n_found_time    = r_have ? r_best_t : '0;
                    n_found_payload = r_have ? r_best_p : '0;
                    n_event_count   = r_count;
                    n_last_time     = (r_count == '0) ? '0 : r_last;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op            <= n_op;
        r_t             <= n_t;
        r_p             <= n_p;
        r_last          <= n_last;
        r_idx           <= n_idx;
        r_have          <= n_have;
        r_best_t        <= n_best_t;
        r_best_p        <= n_best_p;
        r_best_d        <= n_best_d;
        r_res           <= n_res;
        r_status        <= n_status;
        r_found_time    <= n_found_time;
        r_found_payload <= n_found_payload;
        r_event_count   <= n_event_count;
        r_last_time     <= n_last_time;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found_time    = r_found_time;
    assign o_found_payload = r_found_payload;
    assign o_event_count   = r_event_count;
    assign o_last_time     = r_last_time;

endmodule

`default_nettype wire

### rtl/core/tetn_checker.sv
// tetn_props: port level checks for timed_event_table_nearest, bound to the top level
// depends on tetn_pkg
`default_nettype none

module tetn_props #(
    parameter int DEPTH        = tetn_pkg::DEPTH_DEF,
    parameter int TIME_BITS    = tetn_pkg::TIME_BITS_DEF,
    parameter int PAYLOAD_BITS = tetn_pkg::PAYLOAD_BITS_DEF
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_stall,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire tetn_pkg::t_status       o_status,
    input wire logic [TIME_BITS-1:0]    o_found_time,
    input wire logic [PAYLOAD_BITS-1:0] o_found_payload,
    input wire logic [$clog2(DEPTH+1)-1:0] o_event_count,
    input wire logic [TIME_BITS-1:0]    o_last_time
);

    import tetn_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_found_time) && $stable(o_found_payload)
            && $stable(o_event_count) && $stable(o_last_time))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled while an item is in work");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_event_count <= CW'(DEPTH))
        else $error("event count above table depth");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_count == '0) |-> (o_last_time == '0)
            && (o_found_time == '0) && (o_found_payload == '0))
        else $error("empty table reports stored data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> (o_event_count == CW'(DEPTH)))
        else $error("full status with table not full");

endmodule

bind timed_event_table_nearest tetn_props #(
    .DEPTH        (DEPTH),
    .TIME_BITS    (TIME_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_tetn_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_found_time    (o_found_time),
    .o_found_payload (o_found_payload),
    .o_event_count   (o_event_count),
    .o_last_time     (o_last_time)
);

`default_nettype wire
